@@ sv/vpa_pkg.sv @@
`timescale 1ns / 1ps
package vpa_pkg;

	localparam int unsigned MAX_SEGMENTS = 64;
	localparam int unsigned MEM_UNITS    = 65536;
	localparam int unsigned ID_BITS      = 8;

	localparam int unsigned IDX_W   = $clog2(MAX_SEGMENTS);
	localparam int unsigned CNT_W   = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned SIZE_W  = $clog2(MEM_UNITS + 1);
	localparam int unsigned START_W = $clog2(MEM_UNITS);
	localparam int unsigned OWN_W   = (ID_BITS < 8) ? ID_BITS : 8;

	// register select, taken from paddr[2]
	localparam logic REG_FIT   = 1'b0;
	localparam logic REG_TOTAL = 1'b1;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_NOOWNER = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_INIT  = 3'd1,
		OP_MARK  = 3'd2,
		OP_SPLIT = 3'd3,
		OP_MERGE = 3'd4
	} op_t;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [SIZE_W-1:0]  size;
		logic               free;
		logic [OWN_W-1:0]   owner;
	} entry_t;

	typedef struct packed {
		logic               mode;
		logic               policy;
		logic [OWN_W-1:0]   owner;
		logic [SIZE_W-1:0]  want;
		logic [IDX_W-1:0]   cursor;
		logic [CNT_W-1:0]   count;
	} req_t;

	// scan word handed from cell to cell
	typedef struct packed {
		logic               tok;
		logic               a_found;
		logic [IDX_W-1:0]   a_idx;
		logic [SIZE_W-1:0]  a_size;
		logic [START_W-1:0] a_start;
		logic               b_found;
		logic [IDX_W-1:0]   b_idx;
		logic [SIZE_W-1:0]  b_size;
		logic [START_W-1:0] b_start;
		logic               p_free;
		logic [SIZE_W-1:0]  p_size;
		logic               m_prev_free;
		logic [SIZE_W-1:0]  m_prev_size;
		logic               m_want_next;
		logic               m_next_free;
		logic [SIZE_W-1:0]  m_next_size;
	} scan_t;

	typedef struct packed {
		op_t                op;
		logic [IDX_W-1:0]   idx;
		logic [1:0]         shift;
		logic [SIZE_W-1:0]  size;
		logic [START_W-1:0] rem_start;
		logic [SIZE_W-1:0]  rem_size;
		logic [OWN_W-1:0]   owner;
	} cmd_t;

endpackage

@@ sv/vpa_cell.sv @@
`timescale 1ns / 1ps
module vpa_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  vpa_pkg::req_t   req,
	input  vpa_pkg::cmd_t   cmd,
	input  logic [vpa_pkg::SIZE_W-1:0] init_total,
	input  vpa_pkg::scan_t  carry_in,
	output vpa_pkg::scan_t  carry_out,
	input  vpa_pkg::entry_t nb_prev,
	input  vpa_pkg::entry_t nb_next1,
	input  vpa_pkg::entry_t nb_next2,
	output vpa_pkg::entry_t ent
);

	localparam logic [vpa_pkg::CNT_W-1:0] MY  = vpa_pkg::CNT_W'(CELL_IDX);
	localparam logic [vpa_pkg::IDX_W-1:0] MYI = vpa_pkg::IDX_W'(CELL_IDX);

	vpa_pkg::entry_t ent_q;
	vpa_pkg::scan_t  carry_q;
	vpa_pkg::scan_t  nxt;
	logic            valid;
	logic            fits;
	logic [vpa_pkg::CNT_W-1:0] cidx;

	assign valid = MY < req.count;
	assign fits  = valid && ent_q.free && (ent_q.size >= req.want);
	assign cidx  = {1'b0, cmd.idx};

	always_comb begin
		nxt = carry_in;
		nxt.p_free = valid && ent_q.free;
		nxt.p_size = ent_q.size;
		if (req.mode == vpa_pkg::MODE_RELEASE) begin
			if (!carry_in.a_found && valid && !ent_q.free && ent_q.owner == req.owner) begin
				nxt.a_found     = 1'b1;
				nxt.a_idx       = MYI;
				nxt.a_size      = ent_q.size;
				nxt.a_start     = ent_q.start;
				nxt.m_prev_free = carry_in.p_free;
				nxt.m_prev_size = carry_in.p_size;
				nxt.m_want_next = 1'b1;
			end else if (carry_in.m_want_next) begin
				nxt.m_next_free = valid && ent_q.free;
				nxt.m_next_size = ent_q.size;
				nxt.m_want_next = 1'b0;
			end
		end else if (req.policy) begin
			// first fit at or after the cursor, and first fit overall for the wrap
			if (fits && !carry_in.a_found && MY >= {1'b0, req.cursor}) begin
				nxt.a_found = 1'b1;
				nxt.a_idx   = MYI;
				nxt.a_size  = ent_q.size;
				nxt.a_start = ent_q.start;
			end
			if (fits && !carry_in.b_found) begin
				nxt.b_found = 1'b1;
				nxt.b_idx   = MYI;
				nxt.b_size  = ent_q.size;
				nxt.b_start = ent_q.start;
			end
		end else begin
			if (fits && (!carry_in.a_found || ent_q.size > carry_in.a_size)) begin
				nxt.a_found = 1'b1;
				nxt.a_idx   = MYI;
				nxt.a_size  = ent_q.size;
				nxt.a_start = ent_q.start;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q.tok <= 1'b0;
		end else if (carry_in.tok) begin
			carry_q <= nxt;
		end else begin
			carry_q.tok <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.start <= '0;
			ent_q.size  <= vpa_pkg::SIZE_W'(vpa_pkg::MEM_UNITS);
			ent_q.free  <= 1'b1;
			ent_q.owner <= '0;
		end else begin
			case (cmd.op)
				vpa_pkg::OP_INIT: begin
					ent_q.start <= '0;
					ent_q.size  <= init_total;
					ent_q.free  <= 1'b1;
					ent_q.owner <= '0;
				end
				vpa_pkg::OP_MARK: begin
					if (MY == cidx) begin
						ent_q.free  <= 1'b0;
						ent_q.owner <= cmd.owner;
					end
				end
				vpa_pkg::OP_SPLIT: begin
					if (MY == cidx) begin
						ent_q.size  <= cmd.size;
						ent_q.free  <= 1'b0;
						ent_q.owner <= cmd.owner;
					end else if (MY == cidx + 1'b1) begin
						ent_q.start <= cmd.rem_start;
						ent_q.size  <= cmd.rem_size;
						ent_q.free  <= 1'b1;
						ent_q.owner <= '0;
					end else if (MY > cidx + 1'b1) begin
						ent_q <= nb_prev;
					end
				end
				vpa_pkg::OP_MERGE: begin
					if (MY == cidx) begin
						ent_q.size  <= cmd.size;
						ent_q.free  <= 1'b1;
						ent_q.owner <= '0;
					end else if (MY > cidx) begin
						if (cmd.shift == 2'd1) begin
							ent_q <= nb_next1;
						end else if (cmd.shift == 2'd2) begin
							ent_q <= nb_next2;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign carry_out = carry_q;
	assign ent       = ent_q;

endmodule

@@ sv/vpa_ctrl.sv @@
`timescale 1ns / 1ps
module vpa_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic                        s_mode,
	input  logic [vpa_pkg::OWN_W-1:0]   s_owner,
	input  logic [vpa_pkg::SIZE_W-1:0]  s_want,
	input  logic                        fit_policy,
	input  logic                        init,
	input  vpa_pkg::scan_t              tail,
	output logic                        launch,
	output vpa_pkg::req_t               req,
	output vpa_pkg::cmd_t               cmd,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output vpa_pkg::status_t            status,
	output logic [vpa_pkg::START_W-1:0] granted
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_APPLY = 3'b100
	} state_t;

	state_t state_q;
	logic   launch_q;
	logic   mode_q, policy_q;
	logic [vpa_pkg::OWN_W-1:0]   owner_q;
	logic [vpa_pkg::SIZE_W-1:0]  want_q;
	logic [vpa_pkg::CNT_W-1:0]   count_q;
	logic [vpa_pkg::IDX_W-1:0]   cursor_q;
	logic                        m_valid_q;
	vpa_pkg::status_t            status_q;
	logic [vpa_pkg::START_W-1:0] granted_q;

	logic go;
	logic pick_found, split;
	logic [vpa_pkg::IDX_W-1:0]   pick_idx, base_idx;
	logic [vpa_pkg::SIZE_W-1:0]  pick_size, merged;
	logic [vpa_pkg::START_W-1:0] pick_start;
	logic [vpa_pkg::CNT_W-1:0]   idx1, count_n, cur_c, base_c;
	logic [vpa_pkg::IDX_W-1:0]   cursor_n;
	logic [1:0]                  shift;
	vpa_pkg::status_t            st_n;
	logic [vpa_pkg::START_W-1:0] gs_n;

	assign go = (state_q == S_APPLY) && (!m_valid_q || m_tready);

	always_comb begin
		if (policy_q && !tail.a_found) begin
			pick_found = tail.b_found;
			pick_idx   = tail.b_idx;
			pick_size  = tail.b_size;
			pick_start = tail.b_start;
		end else begin
			pick_found = tail.a_found;
			pick_idx   = tail.a_idx;
			pick_size  = tail.a_size;
			pick_start = tail.a_start;
		end
		split    = pick_size > want_q;
		idx1     = {1'b0, pick_idx} + 1'b1;
		cur_c    = {1'b0, cursor_q};
		base_idx = tail.m_prev_free ? tail.a_idx - 1'b1 : tail.a_idx;
		base_c   = {1'b0, base_idx};
		shift    = {1'b0, tail.m_prev_free} + {1'b0, tail.m_next_free};
		merged   = tail.a_size + (tail.m_prev_free ? tail.m_prev_size : '0)
			+ (tail.m_next_free ? tail.m_next_size : '0);

		cmd       = '0;
		cmd.op    = vpa_pkg::OP_NONE;
		cmd.owner = owner_q;
		st_n      = vpa_pkg::ST_OK;
		gs_n      = '0;
		count_n   = count_q;
		cursor_n  = cursor_q;

		if (mode_q == vpa_pkg::MODE_RELEASE) begin
			if (!tail.a_found) begin
				st_n = vpa_pkg::ST_NOOWNER;
			end else begin
				cmd.op    = vpa_pkg::OP_MERGE;
				cmd.idx   = base_idx;
				cmd.shift = shift;
				cmd.size  = merged;
				count_n   = count_q - {{(vpa_pkg::CNT_W-2){1'b0}}, shift};
				if (cur_c > base_c) begin
					if (cur_c >= base_c + {{(vpa_pkg::CNT_W-2){1'b0}}, shift}) begin
						cursor_n = cursor_q - {{(vpa_pkg::IDX_W-2){1'b0}}, shift};
					end else begin
						cursor_n = base_idx;
					end
				end
			end
		end else if (want_q == '0 || !pick_found) begin
			st_n = vpa_pkg::ST_NOFIT;
		end else if (split && count_q >= vpa_pkg::CNT_W'(vpa_pkg::MAX_SEGMENTS)) begin
			st_n = vpa_pkg::ST_FULL;
		end else begin
			gs_n    = pick_start;
			cmd.idx = pick_idx;
			if (split) begin
				cmd.op        = vpa_pkg::OP_SPLIT;
				cmd.size      = want_q;
				cmd.rem_start = pick_start + want_q[vpa_pkg::START_W-1:0];
				cmd.rem_size  = pick_size - want_q;
				count_n       = count_q + 1'b1;
				if (cursor_q > pick_idx) begin
					cursor_n = cursor_q + 1'b1;
				end
			end else begin
				cmd.op = vpa_pkg::OP_MARK;
			end
			if (policy_q) begin
				cursor_n = (idx1 < count_n) ? pick_idx + 1'b1 : '0;
			end
		end

		if (!go) begin
			cmd.op = vpa_pkg::OP_NONE;
		end
		if (init) begin
			cmd.op = vpa_pkg::OP_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			launch_q  <= 1'b0;
			count_q   <= vpa_pkg::CNT_W'(1);
			cursor_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			launch_q <= (state_q == S_IDLE) && s_tvalid;
			if (go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (init) begin
				count_q  <= vpa_pkg::CNT_W'(1);
				cursor_q <= '0;
			end else if (go) begin
				count_q  <= count_n;
				cursor_q <= cursor_n;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (tail.tok) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			mode_q   <= s_mode;
			owner_q  <= s_owner;
			want_q   <= s_want;
			policy_q <= fit_policy;
		end
		if (go) begin
			status_q  <= st_n;
			granted_q <= gs_n;
		end
	end

	assign s_tready   = (state_q == S_IDLE);
	assign launch     = launch_q;
	assign req.mode   = mode_q;
	assign req.policy = policy_q;
	assign req.owner  = owner_q;
	assign req.want   = want_q;
	assign req.cursor = cursor_q;
	assign req.count  = count_q;
	assign m_tvalid   = m_valid_q;
	assign status     = status_q;
	assign granted    = granted_q;

endmodule

@@ sv/variable_partition_allocator.sv @@
`timescale 1ns / 1ps
// Channel   Dir   Width  Contents
// s_*       in    32/1   request word: tdata owner_id, request_size; tuser mode
// m_*       out   16/2   result word: tdata granted_start; tuser status
// apb       in    32     fit_policy at 0x0, memory size at 0x4
//
// A request passes from accept to result through the launch register, then the chain
// of cell registers that the scan word walks one cell at a time, then the update
// state, which acts on the tail word and splits, marks or merges the table in every
// cell at once. The next word can be accepted once the update is done.
// Only one request is in flight; the result register frees the input side.
// A stalled result holds the update cycle until the result word is taken.
// Reset leaves one free segment covering all units; no clearing pass.
module variable_partition_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [7:0] owner_id, [24:8] request_size, rest zero
	input  logic        s_tuser,  // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [15:0] granted_start
	output logic [1:0]  m_tuser,  // [1:0] status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned N = vpa_pkg::MAX_SEGMENTS;

	logic                        fit_q;
	logic [vpa_pkg::SIZE_W-1:0]  total_q;
	logic [vpa_pkg::SIZE_W-1:0]  total_w;
	logic                        wr, init;
	logic                        launch;
	vpa_pkg::req_t               req;
	vpa_pkg::cmd_t               cmd;
	vpa_pkg::scan_t              carry [N+1];
	vpa_pkg::entry_t             ent [N];
	vpa_pkg::status_t            status;
	logic [vpa_pkg::START_W-1:0] granted;

	// APB: always ready, one write per access phase
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign init   = wr && (paddr[2] == vpa_pkg::REG_TOTAL);

	// clamp the written total into the managed range
	always_comb begin
		if (pwdata == 32'd0) begin
			total_w = vpa_pkg::SIZE_W'(1);
		end else if (pwdata > 32'(vpa_pkg::MEM_UNITS)) begin
			total_w = vpa_pkg::SIZE_W'(vpa_pkg::MEM_UNITS);
		end else begin
			total_w = pwdata[vpa_pkg::SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q   <= 1'b0;
			total_q <= vpa_pkg::SIZE_W'(vpa_pkg::MEM_UNITS);
		end else if (wr) begin
			if (paddr[2] == vpa_pkg::REG_FIT) begin
				fit_q <= pwdata[0];
			end else begin
				total_q <= total_w;
			end
		end
	end

	assign prdata = (paddr[2] == vpa_pkg::REG_FIT) ? {31'd0, fit_q} : 32'(total_q);

	// head of the chain: a fresh scan word with nothing found yet
	always_comb begin
		carry[0]     = '0;
		carry[0].tok = launch;
	end

	// row of segment cells; cell i holds table entry i
	for (genvar i = 0; i < N; i++) begin : g_cell
		vpa_pkg::entry_t prev_e, next1_e, next2_e;
		if (i > 0) begin : g_p
			assign prev_e = ent[i-1];
		end else begin : g_p0
			assign prev_e = '0;
		end
		if (i + 1 < N) begin : g_n1
			assign next1_e = ent[i+1];
		end else begin : g_n1z
			assign next1_e = '0;
		end
		if (i + 2 < N) begin : g_n2
			assign next2_e = ent[i+2];
		end else begin : g_n2z
			assign next2_e = '0;
		end
		vpa_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.req        (req),
			.cmd        (cmd),
			.init_total (total_w),
			.carry_in   (carry[i]),
			.carry_out  (carry[i+1]),
			.nb_prev    (prev_e),
			.nb_next1   (next1_e),
			.nb_next2   (next2_e),
			.ent        (ent[i])
		);
	end

	// sequencer: accept, launch the scan, act on the tail word, emit the result
	vpa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_mode     (s_tuser),
		.s_owner    (s_tdata[vpa_pkg::OWN_W-1:0]),
		.s_want     (s_tdata[8 +: vpa_pkg::SIZE_W]),
		.fit_policy (fit_q),
		.init       (init),
		.tail       (carry[N]),
		.launch     (launch),
		.req        (req),
		.cmd        (cmd),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.status     (status),
		.granted    (granted)
	);

	assign m_tdata = granted;
	assign m_tuser = status;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		req.count >= vpa_pkg::CNT_W'(1) && req.count <= vpa_pkg::CNT_W'(N))
		else $error("segment count out of range");
	a_cursor_live: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, req.cursor} < req.count)
		else $error("roving cursor past last segment");
	a_first_start: assert property (@(posedge clk) disable iff (!arst_n)
		ent[0].start == '0)
		else $error("first segment does not start at zero");
	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		carry[N].tok |-> !s_tready)
		else $error("scan finished while idle");
`endif

endmodule
